// File: src/e2c_pkg.sv
// Shared types, constants and helpers for the epoch to calendar converter.
package e2c_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned ProdW  = 2 * EpochW;

  // n / 60 == (n * Recip60) >> 37 and n / 24 == (n * Recip24) >> 36, any 32-bit n
  localparam logic [EpochW-1:0] Recip60   = 32'h8888_8889;
  localparam int unsigned       Recip60Sh = 37;
  localparam logic [EpochW-1:0] Recip24   = 32'hAAAA_AAAB;
  localparam int unsigned       Recip24Sh = 36;

  // n / 7 == (n * Recip7) >> 20 for any 17-bit n
  localparam int unsigned        Recip7W  = 18;
  localparam logic [Recip7W-1:0] Recip7   = 18'h24925;
  localparam int unsigned        Recip7Sh = 20;

  localparam logic [3:0] DaysPerWk  = 4'd7;
  localparam logic [2:0] WdayOrigin = 3'd4;   // 1970-01-01 was a Thursday

  localparam logic [8:0] LeapYearLen = 9'd366;
  localparam logic [8:0] YearLen     = 9'd365;

  // 1970 taken modulo 4, 100 and 400
  localparam logic [1:0] Y0Mod4   = 2'd2;
  localparam logic [6:0] Y0Mod100 = 7'd70;
  localparam logic [8:0] Y0Mod400 = 9'd370;
  localparam logic [6:0] Cent     = 7'd99;
  localparam logic [8:0] QuadCent = 9'd399;

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] MonthEnd  = 4'd12;
  localparam logic [3:0] Feb       = 4'd1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SPLIT,
    F_HOLD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WDAY,
    B_YEAR,
    B_MONTH,
    B_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    P_SEC,
    P_MIN,
    P_HOUR
  } div_pass_t;

  // Time of day and whole day count of one request.
  typedef struct packed {
    logic [5:0]       sec;
    logic [5:0]       min;
    logic [4:0]       hour;
    logic [DaysW-1:0] days;
  } split_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      Feb:                                       len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/e2c_front.sv
// Front end: takes a request and splits it into seconds, minutes, hours and days.
module e2c_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [e2c_pkg::EpochW-1:0]        in_epoch_seconds,
  output logic                              q_push,
  input  logic                              q_full,
  output e2c_pkg::split_t                   q_data
);
  import e2c_pkg::*;

  front_state_t      state_r, state_nxt;
  div_pass_t         pass_r, pass_nxt;
  logic [EpochW-1:0] quo_r, quo_nxt;
  logic [ProdW-1:0]  prod_r, prod_nxt;
  logic [5:0]        sec_r, sec_nxt;
  logic [5:0]        min_r, min_nxt;
  split_t            rec_r, rec_nxt;

  logic [EpochW-1:0] recip;
  logic [EpochW-1:0] quo;
  logic [5:0]        rem60;
  logic [4:0]        rem24;

  // remainder from low bits: x - 60q == x + 4q mod 64, x - 24q == x + 8q mod 32
  always_comb begin
    recip = (pass_r == P_HOUR) ? Recip24 : Recip60;
    quo   = (pass_r == P_HOUR) ? EpochW'(prod_r[ProdW-1:Recip24Sh])
                               : EpochW'(prod_r[ProdW-1:Recip60Sh]);
    rem60 = 6'(quo_r[5:0] + {quo[3:0], 2'b00});
    rem24 = 5'(quo_r[4:0] + {quo[1:0], 3'b000});
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    quo_nxt   = quo_r;
    prod_nxt  = prod_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    rec_nxt   = rec_r;
    q_push    = 1'b0;
    full      = state_r != F_IDLE;
    unique case (state_r)
      F_IDLE: begin
        if (push) begin
          quo_nxt   = in_epoch_seconds;
          pass_nxt  = P_SEC;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        prod_nxt  = ProdW'(quo_r) * ProdW'(recip);
        state_nxt = F_SPLIT;
      end
      F_SPLIT: begin
        quo_nxt   = quo;
        state_nxt = F_MUL;
        unique case (pass_r)
          P_SEC: begin
            sec_nxt  = rem60;
            pass_nxt = P_MIN;
          end
          P_MIN: begin
            min_nxt  = rem60;
            pass_nxt = P_HOUR;
          end
          default: begin
            rec_nxt.sec  = sec_r;
            rec_nxt.min  = min_r;
            rec_nxt.hour = rem24;
            rec_nxt.days = quo[DaysW-1:0];
            state_nxt    = F_HOLD;
          end
        endcase
      end
      F_HOLD: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_data = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pass_r  <= P_SEC;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    prod_r <= prod_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    rec_r  <= rec_nxt;
  end

  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_SPLIT |-> (pass_r == P_SEC || pass_r == P_MIN || pass_r == P_HOUR))
    else $error("divider pass out of range");

endmodule

// File: src/e2c_fifo.sv
// Short queue between the front end and the back end.
module e2c_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  e2c_pkg::split_t wr_data,
  output logic            q_full,
  input  logic            rd_en,
  output e2c_pkg::split_t rd_data,
  output logic            q_empty
);
  import e2c_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  split_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign q_full  = cnt_r == CW'(DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: src/e2c_back.sv
// Back end: weekday, year and month search, and the result register.
module e2c_back (
  input  logic            clk,
  input  logic            rst_n,
  input  e2c_pkg::split_t rd_data,
  input  logic            q_empty,
  output logic            rd_en,
  output logic            empty,
  input  logic            pop,
  output logic [5:0]      out_sec_of_min,
  output logic [5:0]      out_min_of_hour,
  output logic [4:0]      out_hour_of_day,
  output logic [2:0]      out_week_day,
  output logic [7:0]      out_year_offset,
  output logic [3:0]      out_month_num,
  output logic [4:0]      out_day_of_month
);
  import e2c_pkg::*;

  localparam int unsigned WW     = DaysW + 1;
  localparam int unsigned WProdW = WW + Recip7W;

  back_state_t      state_r, state_nxt;
  split_t           rec_r, rec_nxt;
  logic [WW-1:0]    wsh_r, wsh_nxt;
  logic [2:0]       wrem_r, wrem_nxt;
  logic [DaysW-1:0] rem_r, rem_nxt;
  logic [7:0]       yoff_r, yoff_nxt;
  logic [1:0]       m4_r, m4_nxt;
  logic [6:0]       m100_r, m100_nxt;
  logic [8:0]       m400_r, m400_nxt;
  logic [3:0]       mon_r, mon_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [WProdW-1:0] wprod;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic              load_out;

  // x - 7q == x + q mod 8
  always_comb begin
    wprod = WProdW'(wsh_r) * WProdW'(Recip7);
    leap  = (m4_r == '0) && ((m100_r != '0) || (m400_r == '0));
    ylen  = leap ? LeapYearLen : YearLen;
    mlen  = month_len(mon_r, leap);
  end

  always_comb begin
    state_nxt     = state_r;
    rec_nxt       = rec_r;
    wsh_nxt       = wsh_r;
    wrem_nxt      = wrem_r;
    rem_nxt       = rem_r;
    yoff_nxt      = yoff_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    mon_nxt       = mon_r;
    out_valid_nxt = out_valid_r && !pop;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          rd_en     = 1'b1;
          rec_nxt   = rd_data;
          wsh_nxt   = WW'({1'b0, rd_data.days} + WW'(WdayOrigin));
          rem_nxt   = rd_data.days;
          yoff_nxt  = '0;
          m4_nxt    = Y0Mod4;
          m100_nxt  = Y0Mod100;
          m400_nxt  = Y0Mod400;
          state_nxt = B_WDAY;
        end
      end
      B_WDAY: begin
        wrem_nxt  = 3'(wsh_r[2:0] + wprod[Recip7Sh+2:Recip7Sh]);
        state_nxt = B_YEAR;
      end
      B_YEAR: begin
        if (rem_r >= DaysW'(ylen)) begin
          rem_nxt  = DaysW'(rem_r - DaysW'(ylen));
          yoff_nxt = 8'(yoff_r + 8'd1);
          m4_nxt   = 2'(m4_r + 2'd1);
          m100_nxt = (m100_r == Cent) ? '0 : 7'(m100_r + 7'd1);
          m400_nxt = (m400_r == QuadCent) ? '0 : 9'(m400_r + 9'd1);
        end else begin
          mon_nxt   = '0;
          state_nxt = B_MONTH;
        end
      end
      B_MONTH: begin
        if (mon_r == MonthEnd || rem_r < DaysW'(mlen)) begin
          state_nxt = B_OUT;
        end else begin
          rem_nxt = DaysW'(rem_r - DaysW'(mlen));
          mon_nxt = 4'(mon_r + 4'd1);
        end
      end
      B_OUT: begin
        if (!out_valid_r || pop) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    wsh_r  <= wsh_nxt;
    wrem_r <= wrem_nxt;
    rem_r  <= rem_nxt;
    yoff_r <= yoff_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
    mon_r  <= mon_nxt;
    if (load_out) begin
      out_sec_of_min   <= rec_r.sec;
      out_min_of_hour  <= rec_r.min;
      out_hour_of_day  <= rec_r.hour;
      out_week_day     <= 3'(wrem_r + 3'd1);
      out_year_offset  <= yoff_r;
      out_month_num    <= 4'(((mon_r > LastMonth) ? LastMonth : mon_r) + 4'd1);
      out_day_of_month <= 5'(rem_r[4:0] + 5'd1);
    end
  end

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_YEAR |-> yoff_r <= 8'd136)
    else $error("year offset beyond range");

  a_wday_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_YEAR |-> wrem_r < 3'(DaysPerWk))
    else $error("weekday remainder not reduced");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && (!out_valid_r || pop)) |=> (out_valid_r && state_r == B_IDLE))
    else $error("result not presented after load");

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_MONTH |-> mon_r <= MonthEnd)
    else $error("month search ran past December");

endmodule

// File: src/epoch_to_calendar.sv
// Top level: epoch seconds to calendar date and time of day.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  input   | push / full      | in_epoch_seconds
//  result  | pop / empty      | out_sec_of_min .. out_day_of_month
//
// Front end: 3 reciprocal multiplications (by 60, 60, 24), each an F_MUL and an
// F_SPLIT state, between accepting a request and handing it over. Back end: take
// a request and find the weekday, step the years one by one, then the months one
// by one, then load the result. Each end handles one request at a time.
// Synchronous active-low reset empties the queue and the result register.
// A result held by a low pop stalls the back end; the front keeps working until the queue is full.
module epoch_to_calendar #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [e2c_pkg::EpochW-1:0] in_epoch_seconds,
  output logic                       empty,
  input  logic                       pop,
  output logic [5:0]                 out_sec_of_min,
  output logic [5:0]                 out_min_of_hour,
  output logic [4:0]                 out_hour_of_day,
  output logic [2:0]                 out_week_day,
  output logic [7:0]                 out_year_offset,
  output logic [3:0]                 out_month_num,
  output logic [4:0]                 out_day_of_month
);
  import e2c_pkg::*;

  logic   q_push, q_full, q_rd, q_empty;
  split_t q_wdata, q_rdata;

  e2c_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_epoch_seconds (in_epoch_seconds),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_data           (q_wdata)
  );

  e2c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  e2c_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rd_data          (q_rdata),
    .q_empty          (q_empty),
    .rd_en            (q_rd),
    .empty            (empty),
    .pop              (pop),
    .out_sec_of_min   (out_sec_of_min),
    .out_min_of_hour  (out_min_of_hour),
    .out_hour_of_day  (out_hour_of_day),
    .out_week_day     (out_week_day),
    .out_year_offset  (out_year_offset),
    .out_month_num    (out_month_num),
    .out_day_of_month (out_day_of_month)
  );

endmodule

// File: sim/epoch_to_calendar_tb.sv
// Testbench for epoch_to_calendar: queued epoch requests checked against a calendar predictor.
module epoch_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned LongHoldAt    = 700;
  localparam int unsigned LongHold      = 3000;
  localparam int unsigned BatchLen      = 500;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [2:0] wday;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
  } calendar_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic [e2c_pkg::EpochW-1:0] in_epoch_seconds = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [5:0]                 out_sec_of_min;
  logic [5:0]                 out_min_of_hour;
  logic [4:0]                 out_hour_of_day;
  logic [2:0]                 out_week_day;
  logic [7:0]                 out_year_offset;
  logic [3:0]                 out_month_num;
  logic [4:0]                 out_day_of_month;

  logic [e2c_pkg::EpochW-1:0] epoch_q[$];
  calendar_t                  calendar_q[$];
  calendar_t                  cal_exp;
  int unsigned                fail_cnt = 0;
  int unsigned                send_gap = 0;
  int unsigned                recv_gap = 0;
  int unsigned                recv_cnt = 0;
  int unsigned                stall_cycles = 0;
  bit                         send_idle_en = 1'b1;
  bit                         recv_idle_en = 1'b1;

  epoch_to_calendar u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_epoch_seconds (in_epoch_seconds),
    .empty            (empty),
    .pop              (pop),
    .out_sec_of_min   (out_sec_of_min),
    .out_min_of_hour  (out_min_of_hour),
    .out_hour_of_day  (out_hour_of_day),
    .out_week_day     (out_week_day),
    .out_year_offset  (out_year_offset),
    .out_month_num    (out_month_num),
    .out_day_of_month (out_day_of_month)
  );

  always #2 clk = ~clk;

  function automatic bit yr_is_leap(int unsigned yoff);
    int unsigned y;
    y = 1970 + yoff;
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_year(int unsigned yoff);
    return yr_is_leap(yoff) ? 366 : 365;
  endfunction

  function automatic int unsigned first_day_of_year(int unsigned yoff);
    int unsigned d;
    d = 0;
    for (int unsigned y = 0; y < yoff; y++) d += days_in_year(y);
    return d;
  endfunction

  function automatic calendar_t to_calendar(logic [e2c_pkg::EpochW-1:0] secs);
    int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    calendar_t   c;
    int unsigned t;
    int unsigned days;
    int unsigned yoff;
    int unsigned mon;
    int unsigned mlen;
    t = secs;
    c.sec = 6'(t % 60);
    t = t / 60;
    c.min = 6'(t % 60);
    t = t / 60;
    c.hour = 5'(t % 24);
    days = t / 24;
    c.wday = 3'((days + 4) % 7 + 1);   // day zero was a Thursday
    yoff = 0;
    while (days >= days_in_year(yoff)) begin
      days -= days_in_year(yoff);
      yoff++;
    end
    mon = 0;
    while (mon < 12) begin
      mlen = (mon == 1) ? (yr_is_leap(yoff) ? 29 : 28) : month_days[mon];
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    if (mon > 11) mon = 11;
    c.year  = 8'(yoff);
    c.month = 4'(mon + 1);
    c.mday  = 5'(days + 1);
    return c;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // wait until every request has been answered
  task automatic drain_all();
    while (epoch_q.size() != 0 || calendar_q.size() != 0 || push) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_epoch_seconds <= '0;
    end else begin
      if (push && !full) begin
        void'(epoch_q.pop_front());
        calendar_q.push_back(to_calendar(in_epoch_seconds));
        send_gap = send_idle_en ? idle_len() : 0;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (epoch_q.size() > 0) begin
        push <= 1'b1;
        in_epoch_seconds <= epoch_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        recv_cnt++;
        if (calendar_q.size() == 0) begin
          $error("result popped with no request outstanding");
          fail_cnt++;
        end else begin
          cal_exp = calendar_q.pop_front();
          check_field("out_sec_of_min", cal_exp.sec, out_sec_of_min);
          check_field("out_min_of_hour", cal_exp.min, out_min_of_hour);
          check_field("out_hour_of_day", cal_exp.hour, out_hour_of_day);
          check_field("out_week_day", cal_exp.wday, out_week_day);
          check_field("out_year_offset", cal_exp.year, out_year_offset);
          check_field("out_month_num", cal_exp.month, out_month_num);
          check_field("out_day_of_month", cal_exp.mday, out_day_of_month);
        end
        if (recv_cnt == LongHoldAt) recv_gap = LongHold;
        else recv_gap = recv_idle_en ? idle_len() : 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [e2c_pkg::EpochW-1:0] corner_secs[$] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000,
      32'd951782400, 32'd951868799, 32'd978307199, 32'h7FFF_FFFF,
      32'd4107542399, 32'd4107542400, 32'd4291747199, 32'd4291747200,
      32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    logic [e2c_pkg::EpochW-1:0] secs;
    int unsigned                kind;
    int unsigned                yoff;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_secs[i]) epoch_q.push_back(corner_secs[i]);
    drain_all();

    // middle batch runs flat out and takes the long receiver hold-off
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_en = (phase != 1);
      recv_idle_en = (phase != 1);
      repeat (BatchLen) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          secs = $urandom();
        end else if (kind < 7) begin
          // last or first second of a year
          yoff = $urandom_range(1, 136);
          secs = 32'(first_day_of_year(yoff) * 86400 - $urandom_range(0, 1));
        end else if (kind < 9) begin
          // around the end of February
          yoff = $urandom_range(0, 135);
          secs = 32'((first_day_of_year(yoff) + $urandom_range(57, 60)) * 86400
                     + $urandom_range(0, 86399));
        end else begin
          secs = $urandom_range(0, 100000);
        end
        epoch_q.push_back(secs);
      end
      drain_all();
    end

    repeat (300) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/e2c_pkg.sv
src/e2c_front.sv
src/e2c_fifo.sv
src/e2c_back.sv
src/epoch_to_calendar.sv
sim/epoch_to_calendar_tb.sv
